/* sv/msbr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package msbr_pkg;

    localparam int PIX_W         = 8;
    localparam int CFG_W         = 11;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd1024;
    localparam logic [PIX_W-1:0] MSB_MASK    = 8'h80;

    // register index, taken from paddr[2]
    localparam logic REG_IMAGE_WIDTH = 1'b0;

    // x / 3 for x <= 765 as (x * 683) >> 11
    localparam int SUM_W      = PIX_W + 2;
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;
    localparam int PROD_W     = SUM_W + 10;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [PIX_W-1:0] left;
        logic [PIX_W-1:0] above;
        logic [PIX_W-1:0] upper_left;
        logic             predict;
    } t_pred_req;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             flipped;
    } t_pred_rsp;

    function automatic logic [PIX_W-1:0] div3(input logic [SUM_W-1:0] x);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(x) * PROD_W'(DIV3_MUL);
        return prod[DIV3_SHIFT +: PIX_W];
    endfunction

    function automatic logic [PIX_W-1:0] absdiff(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage
`default_nettype wire

/* sv/msbr_row_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
module msbr_row_mem #(
    parameter int DEPTH = msbr_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_re,
    input  wire logic [AW-1:0]              i_raddr,
    output logic      [msbr_pkg::PIX_W-1:0] o_rdata,
    input  wire logic                       i_we,
    input  wire logic [AW-1:0]              i_waddr,
    input  wire logic [msbr_pkg::PIX_W-1:0] i_wdata
);
    import msbr_pkg::*;

    logic [PIX_W-1:0] r_mem [DEPTH];

    // read-first; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

endmodule
`default_nettype wire

/* sv/msbr_predict.sv */
`timescale 1ns / 1ps
`default_nettype none
module msbr_predict (
    input  wire msbr_pkg::t_pred_req i_req,
    output msbr_pkg::t_pred_rsp      o_rsp
);
    import msbr_pkg::*;

    logic [SUM_W-1:0] sum;
    logic [PIX_W-1:0] pred;
    logic [PIX_W-1:0] alt;
    logic             flip;

    always_comb begin
        sum  = SUM_W'(i_req.left) + SUM_W'(i_req.above) + SUM_W'(i_req.upper_left);
        pred = div3(sum);
        alt  = i_req.pixel ^ MSB_MASK;
        // ties go to the inverted pixel
        flip = i_req.predict && (absdiff(pred, i_req.pixel) >= absdiff(pred, alt));
        o_rsp.pixel_out = flip ? alt : i_req.pixel;
        o_rsp.flipped   = flip;
    end

endmodule
`default_nettype wire

/* sv/msb_prediction_recovery.sv */
`timescale 1ns / 1ps
`default_nettype none
// path: input transfer, then the stage 1 registers, then the output register on the master side
// throughput: one pixel per cycle, sustained while the master side accepts; the loop through the
//   predictor carries the left neighbor, the row memory gives the upper one
// reset: synchronous, active low; image width 1024, column 0, first row;
//   the row memory is not cleared, each entry is written before its contents are used
module msb_prediction_recovery #(
    parameter int MAX_WIDTH = msbr_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // pixel stream in
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [7:0]                  s_axis_tdata,   // [7:0] pixel_in
    input  wire logic [0:0]                  s_axis_tuser,   // [0] start_of_image
    // pixel stream out
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [7:0]                  m_axis_tdata,   // [7:0] pixel_out
    output logic      [0:0]                  m_axis_tuser,   // [0] msb_flipped
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [msbr_pkg::APB_AW-1:0] paddr,
    input  wire logic [msbr_pkg::APB_DW-1:0] pwdata,
    output logic      [msbr_pkg::APB_DW-1:0] prdata,
    output logic                             pready
);
    import msbr_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    // compare width for column count against the effective width
    localparam int WW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] r_width;
    logic             reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_IMAGE_WIDTH);
    assign prdata  = reg_hit ? APB_DW'(r_width) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_width <= pwdata[CFG_W-1:0];
        end
    end

    // clamp the width to 2 .. MAX_WIDTH
    logic [WW-1:0] width_raw;
    logic [WW-1:0] eff_width;

    always_comb begin
        width_raw = WW'(r_width);
        if (width_raw < WW'(2)) begin
            eff_width = WW'(2);
        end else if (width_raw > WW'(MAX_WIDTH)) begin
            eff_width = WW'(MAX_WIDTH);
        end else begin
            eff_width = width_raw;
        end
    end

    // ---------------- stage 0: position tracking and memory read ----------------
    logic          r_s1_valid;
    logic          out_free;
    logic          s1_fire;
    logic          in_fire;
    logic          sof;

    logic [AW-1:0] r_col;
    logic          r_first_row;
    logic [AW-1:0] col_cur;
    logic          first_cur;
    logic [AW:0]   col_inc;
    logic          wrap;

    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign s1_fire       = r_s1_valid && out_free;
    // the pipeline moves as a whole: a new pixel enters when stage 1 empties
    assign s_axis_tready = !r_s1_valid || out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign sof           = s_axis_tuser[0];

    always_comb begin
        // start of image restarts at column 0 of the first row
        col_cur   = sof ? '0 : r_col;
        first_cur = sof ? 1'b1 : r_first_row;
        col_inc   = {1'b0, col_cur} + (AW+1)'(1);
        wrap      = (WW'(col_inc) >= eff_width);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_first_row <= 1'b1;
        end else if (in_fire) begin
            r_col       <= wrap ? '0 : col_inc[AW-1:0];
            r_first_row <= wrap ? 1'b0 : first_cur;
        end
    end

    // ---------------- stage 1 registers ----------------
    logic [PIX_W-1:0] r_s1_pixel;
    logic [AW-1:0]    r_s1_addr;
    logic             r_s1_pred;
    logic             r_fwd;
    logic [PIX_W-1:0] r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
            // the pixel leaving stage 1 writes the entry being read now
            r_fwd      <= s1_fire && (r_s1_addr == col_cur);
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_pixel <= s_axis_tdata;
            r_s1_addr  <= col_cur;
            r_s1_pred  <= !first_cur && (col_cur != '0);
        end
    end

    // ---------------- row memory ----------------
    logic [PIX_W-1:0] mem_q;
    logic [PIX_W-1:0] above;
    t_pred_req        req;
    t_pred_rsp        rsp;

    msbr_row_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_row_mem (
        .i_clk   (i_clk),
        .i_re    (in_fire),
        .i_raddr (col_cur),
        .o_rdata (mem_q),
        .i_we    (s1_fire),
        .i_waddr (r_s1_addr),
        .i_wdata (rsp.pixel_out)
    );

    assign above = r_fwd ? r_fwd_data : mem_q;

    // ---------------- prediction ----------------
    logic [PIX_W-1:0] r_left;
    logic [PIX_W-1:0] r_upper_left;

    always_comb begin
        req.pixel      = r_s1_pixel;
        req.left       = r_left;
        req.above      = above;
        req.upper_left = r_upper_left;
        req.predict    = r_s1_pred;
    end

    msbr_predict u_predict (
        .i_req (req),
        .o_rsp (rsp)
    );

    // neighbors advance with each finished pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left       <= '0;
            r_upper_left <= '0;
        end else if (s1_fire) begin
            r_left       <= rsp.pixel_out;
            r_upper_left <= above;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_fwd_data <= rsp.pixel_out;
        end
    end

    // ---------------- output register ----------------
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            m_axis_tdata    <= rsp.pixel_out;
            m_axis_tuser[0] <= rsp.flipped;
        end
    end

    assign m_axis_tvalid = r_out_valid;

    // ---------------- assertions ----------------
    a_fwd_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_s1_valid)
        else $error("forward flag set with stage 1 empty");

    a_sof_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && sof |=> r_col == AW'(1))
        else $error("start of image did not restart at column 0");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_col} < (AW+1)'(MAX_WIDTH))
        else $error("column count out of range");

    a_flip_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> m_axis_tvalid
            && ((m_axis_tdata[7] != $past(r_s1_pixel[7])) == m_axis_tuser[0]))
        else $error("msb_flipped does not match the output pixel");

    a_passthrough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && !r_s1_pred |=> !m_axis_tuser[0])
        else $error("edge pixel was altered");

endmodule
`default_nettype wire
